@@ sv/cmm_pkg.sv @@
// Shared types, constants and helpers for the conference mix-minus mixer.
// Used by cmm_lane, cmm_merge and conference_mix_minus_mixer_core.
package cmm_pkg;

    localparam int NUM_FIELDS = 8;              // sample fields carried by one item
    localparam int PORTS      = 8;              // ports that take part (2..8)
    localparam int SMP_W      = 16;
    localparam int CNT_W      = $clog2(NUM_FIELDS + 1);
    localparam int SHIFT_W    = $clog2($clog2(NUM_FIELDS) + 1);
    localparam int PAIRS      = NUM_FIELDS / 2;
    localparam int PAIR_W     = SMP_W + 1;
    localparam int SUM_W      = SMP_W + $clog2(NUM_FIELDS);
    localparam int IN_W       = NUM_FIELDS * SMP_W + NUM_FIELDS;
    localparam int OUT_W      = ((NUM_FIELDS * SMP_W + NUM_FIELDS + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BRIDGE_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK    = 2'd1;

    typedef logic signed [SMP_W-1:0]     sample_t;
    typedef sample_t [NUM_FIELDS-1:0]    sample_vec_t;
    typedef logic [NUM_FIELDS-1:0]       port_mask_t;

    localparam port_mask_t PORT_MASK = NUM_FIELDS'((1 << PORTS) - 1);

    // control that travels beside the lane data towards the merge stage
    typedef struct packed {
        logic       bridge;
        port_mask_t act;
        port_mask_t nz;     // lane has at least one contributor
        sample_t    smp0;
    } ctl_t;

    // floor(log2(count)) for a contributor count
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [CNT_W-1:0] cnt);
        logic [SHIFT_W-1:0] s;
        s = '0;
        for (int b = 1; b < CNT_W; b++)
        begin
            if (cnt >= CNT_W'(1 << b))
            begin
                s = SHIFT_W'(b);
            end
        end
        return s;
    endfunction

    // clamp a wide sum to the sample range
    function automatic sample_t sat16(input logic signed [SUM_W-1:0] x);
        sample_t r;
        if (x > SUM_W'(32767))
        begin
            r = 16'sh7fff;
        end
        else if (x < -SUM_W'(32768))
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = x[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ sv/cmm_lane.sv @@
// One mixing lane: scales and sums the contributing samples for one port.
// Depends on cmm_pkg. Two register stages, loaded by the enables from the top.
module cmm_lane (
    input  logic                 clk,
    input  logic                 ld_a,
    input  logic                 ld_b,
    input  cmm_pkg::sample_vec_t smp,
    input  cmm_pkg::port_mask_t  contrib,
    output cmm_pkg::sample_t     mix
);
    import cmm_pkg::*;

    logic [CNT_W-1:0]          cnt;
    logic [SHIFT_W-1:0]        sh;
    sample_t                   term [NUM_FIELDS];
    logic signed [PAIR_W-1:0]  pair_next [PAIRS];
    logic signed [PAIR_W-1:0]  pair_reg  [PAIRS];
    logic signed [SUM_W-1:0]   total;
    sample_t                   mix_next;
    sample_t                   mix_reg;

    // scale each contributor by the shared shift, keeping the sign
    always_comb
    begin
        cnt = CNT_W'($countones(contrib));
        sh  = shift_of(cnt);
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            if (contrib[i])
            begin
                term[i] = smp[i] >>> sh;
            end
            else
            begin
                term[i] = '0;
            end
        end
        for (int j = 0; j < PAIRS; j++)
        begin
            pair_next[j] = PAIR_W'(term[2*j]) + PAIR_W'(term[2*j+1]);
        end
    end

    // hold the pair sums
    always_ff @(posedge clk)
    begin
        if (ld_a)
        begin
            pair_reg <= pair_next;
        end
    end

    // finish the sum and saturate
    always_comb
    begin
        total = '0;
        for (int j = 0; j < PAIRS; j++)
        begin
            total = total + SUM_W'(pair_reg[j]);
        end
        mix_next = sat16(total);
    end

    always_ff @(posedge clk)
    begin
        if (ld_b)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix = mix_reg;

endmodule

@@ sv/cmm_merge.sv @@
// Merge stage: picks each port's output from the lanes and forms the result item.
// Depends on cmm_pkg. Holds the output register and its valid bit.
module cmm_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cmm_pkg::ctl_t        ctl,
    input  cmm_pkg::sample_vec_t mix,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cmm_pkg::sample_vec_t out_smp,
    output cmm_pkg::port_mask_t  out_present,
    output logic                 out_comfort
);
    import cmm_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sample_vec_t smp_reg;
    sample_vec_t smp_next;
    port_mask_t  present_reg;
    port_mask_t  present_next;
    logic        comfort_reg;
    logic        comfort_next;

    assign in_ready = !valid_reg || out_ready;

    // choose mix, port 0's sample or silence for every port
    always_comb
    begin
        smp_next     = '0;
        present_next = '0;
        comfort_next = 1'b0;
        if (ctl.bridge)
        begin
            for (int p = 0; p < NUM_FIELDS; p++)
            begin
                if (ctl.act[p])
                begin
                    present_next[p] = 1'b1;
                    if (ctl.nz[p])
                    begin
                        smp_next[p] = mix[p];
                    end
                    else if (p != 0)
                    begin
                        smp_next[p] = ctl.smp0;
                    end
                    else
                    begin
                        comfort_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            present_next[0] = 1'b1;
            if (ctl.nz[0])
            begin
                smp_next[0] = mix[0];
            end
            else
            begin
                comfort_next = 1'b1;
            end
            for (int p = 1; p < NUM_FIELDS; p++)
            begin
                if (ctl.act[p])
                begin
                    present_next[p] = 1'b1;
                    smp_next[p]     = ctl.smp0;
                end
            end
        end
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // load the output item when the slot frees up
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            smp_reg     <= smp_next;
            present_reg <= present_next;
            comfort_reg <= comfort_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_smp     = smp_reg;
    assign out_present = present_reg;
    assign out_comfort = comfort_reg;

endmodule

@@ sv/conference_mix_minus_mixer_core.sv @@
// Conference mix-minus mixer, top level. Depends on cmm_pkg, cmm_lane, cmm_merge.
// A result passes the input reg, the two lane stages and the output reg in order.
// Throughput: one item per cycle while the output is not stalled; one lane per port
// works in parallel.
// Each stage advances when the next is empty or advancing, so bubbles close up.
// Reset (rst_n low, asynchronous) empties the pipeline, sets bridge mode and
// clears the active mask.
module conference_mix_minus_mixer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration writes
    input  logic                               cfg_we,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cmm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [cmm_pkg::IN_W-1:0]           s_axis_tdata,  // port0_in..port7_in, speech_mask
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [cmm_pkg::OUT_W-1:0]          m_axis_tdata,  // port0_out..port7_out, present_mask
    output logic                               m_axis_tuser   // comfort_flag
);
    import cmm_pkg::*;

    logic        bridge_enabled_reg;
    logic        bridge_enabled_next;
    port_mask_t  active_mask_reg;
    port_mask_t  active_mask_next;

    logic        v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic        adv1, adv2, adv3, adv4;

    sample_vec_t smp1_reg;
    port_mask_t  speak1_reg;
    port_mask_t  act1_reg;
    logic        bridge1_reg;

    port_mask_t  contrib [NUM_FIELDS];
    ctl_t        ctl2_next;
    ctl_t        ctl2_reg;
    ctl_t        ctl3_reg;
    sample_vec_t mix3;
    sample_vec_t out_smp;
    port_mask_t  out_present;

    // configuration registers
    always_comb
    begin
        bridge_enabled_next = bridge_enabled_reg;
        active_mask_next    = active_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BRIDGE_ENABLED: bridge_enabled_next = cfg_wdata[0];
                REG_ACTIVE_MASK:    active_mask_next    = cfg_wdata[NUM_FIELDS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_enabled_reg <= 1'b1;
            active_mask_reg    <= '0;
        end
        else
        begin
            bridge_enabled_reg <= bridge_enabled_next;
            active_mask_reg    <= active_mask_next;
        end
    end

    // stage advance chain
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    assign v1_next = adv1 ? s_axis_tvalid : v1_reg;
    assign v2_next = adv2 ? v1_reg : v2_reg;
    assign v3_next = adv3 ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // capture the item with the masks it sees
    always_ff @(posedge clk)
    begin
        if (adv1 && s_axis_tvalid)
        begin
            for (int p = 0; p < NUM_FIELDS; p++)
            begin
                smp1_reg[p] <= s_axis_tdata[p*SMP_W +: SMP_W];
            end
            speak1_reg  <= s_axis_tdata[NUM_FIELDS*SMP_W +: NUM_FIELDS]
                           & active_mask_reg & PORT_MASK;
            act1_reg    <= active_mask_reg & PORT_MASK;
            bridge1_reg <= bridge_enabled_reg;
        end
    end

    // every lane hears the speaking ports but itself
    always_comb
    begin
        for (int p = 0; p < NUM_FIELDS; p++)
        begin
            contrib[p] = speak1_reg & ~(NUM_FIELDS'(1) << p);
            ctl2_next.nz[p] = |contrib[p];
        end
        ctl2_next.bridge = bridge1_reg;
        ctl2_next.act    = act1_reg;
        ctl2_next.smp0   = smp1_reg[0];
    end

    // carry control beside the lanes
    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            ctl2_reg <= ctl2_next;
        end
        if (adv3 && v2_reg)
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    for (genvar g = 0; g < NUM_FIELDS; g++)
    begin : g_lane
        cmm_lane u_lane (
            .clk     (clk),
            .ld_a    (adv2 && v1_reg),
            .ld_b    (adv3 && v2_reg),
            .smp     (smp1_reg),
            .contrib (contrib[g]),
            .mix     (mix3[g])
        );
    end

    cmm_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (v3_reg),
        .in_ready    (adv4),
        .ctl         (ctl3_reg),
        .mix         (mix3),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_smp     (out_smp),
        .out_present (out_present),
        .out_comfort (m_axis_tuser)
    );

    // pack the result item
    always_comb
    begin
        m_axis_tdata = '0;
        for (int p = 0; p < NUM_FIELDS; p++)
        begin
            m_axis_tdata[p*SMP_W +: SMP_W] = out_smp[p];
        end
        m_axis_tdata[NUM_FIELDS*SMP_W +: NUM_FIELDS] = out_present;
    end

    // an empty output slot leaves the whole pipeline free to take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // comfort noise means a silent port 0 that still has an output
    a_comfort_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_smp[0] == '0 && out_present[0])
        else $error("comfort flag with audible or absent port 0");

    // port 1 without an output carries silence
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !out_present[1] |-> out_smp[1] == '0)
        else $error("absent port 1 carries a sample");

    // a filled stage 3 stays filled, its control steady, until the merge stage moves
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !adv4 |=> v3_reg && $stable(ctl3_reg))
        else $error("lane result lost under stall");

endmodule

@@ tb/tb_conference_mix_minus_mixer_core.sv @@
// Self-checking bench for conference_mix_minus_mixer_core: a directed table, then random
// phases under several mix modes, each result checked against an in-bench predictor.
// Depends on cmm_pkg and the core RTL only.
module tb_conference_mix_minus_mixer_core;
    import cmm_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 62;
    localparam int SETTLE       = 10;   // extra idle wait after the last result, to let the pipe empty
    localparam int CHOKE_LEN    = 60;

    // indexes past the register list; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam port_mask_t LIVE_PORTS = port_mask_t'((1 << PORTS) - 1);

    // speech mask in the top byte, port 0 sample in the lowest bits
    typedef struct packed {
        port_mask_t  speech;
        sample_vec_t smp;
    } mix_in_t;

    // comfort flag travels on tuser, above the tdata bits
    typedef struct packed {
        logic        comfort;
        port_mask_t  present;
        sample_vec_t smp;
    } mix_out_t;

    typedef struct {
        logic       bridge;
        port_mask_t act;
        mix_in_t    item;
        logic       typed;
        mix_out_t   want;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;

    // mode as the block should hold it
    logic       bridge_mode = 1'b1;
    port_mask_t conn_mask = '0;

    mix_out_t mix_expected[$];
    row_t     plan[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       calm = 1'b0;
    bit       choke_go = 1'b0;
    bit       choke_taken = 1'b0;
    int       choke_left = 0;

    conference_mix_minus_mixer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // Give up when the run takes far longer than any correct run could
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, mix_expected.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Scaled sum of the contributing ports, shift by floor(log2(count)), then clamp
    function automatic sample_t mixdown(input sample_vec_t smp, input port_mask_t who);
        int n;
        int sh;
        int acc;
        int v;
        n = $countones(who);
        sh = 0;
        acc = 0;
        while (n > 1)
        begin
            sh++;
            n = n >> 1;
        end
        for (int p = 0; p < PORTS; p++)
        begin
            if (who[p])
            begin
                v = smp[p];
                acc += v >>> sh;
            end
        end
        if (acc > 32767)
        begin
            acc = 32767;
        end
        else if (acc < -32768)
        begin
            acc = -32768;
        end
        return sample_t'(acc);
    endfunction

    // Expected outputs for one item under the current mode
    function automatic mix_out_t mix_minus(input mix_in_t it);
        mix_out_t   r;
        port_mask_t act;
        port_mask_t speak;
        port_mask_t contrib;
        r = '0;
        act = conn_mask & LIVE_PORTS;
        speak = it.speech & act;
        if (bridge_mode)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                if (act[p])
                begin
                    r.present[p] = 1'b1;
                    contrib = speak & ~(port_mask_t'(1) << p);
                    if (contrib != '0)
                    begin
                        r.smp[p] = mixdown(it.smp, contrib);
                    end
                    else if (p != 0)
                    begin
                        r.smp[p] = it.smp[0];
                    end
                    else
                    begin
                        r.comfort = 1'b1;
                    end
                end
            end
        end
        else
        begin
            // local speaker always gets an output
            contrib = speak & ~port_mask_t'(1);
            r.present[0] = 1'b1;
            if (contrib != '0)
            begin
                r.smp[0] = mixdown(it.smp, contrib);
            end
            else
            begin
                r.comfort = 1'b1;
            end
            for (int p = 1; p < PORTS; p++)
            begin
                if (act[p])
                begin
                    r.present[p] = 1'b1;
                    r.smp[p] = it.smp[0];
                end
            end
        end
        return r;
    endfunction

    function automatic sample_vec_t spread(input sample_t a, input sample_t b);
        return {{(NUM_FIELDS - 1){b}}, a};
    endfunction

    function automatic void add_row(input logic bridge, input port_mask_t act,
                                    input port_mask_t speech, input sample_vec_t smp,
                                    input logic typed, input mix_out_t want);
        row_t r;
        r.bridge = bridge;
        r.act = act;
        r.item = {speech, smp};
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endfunction

    function automatic sample_t any_sample(input bit loud, input bit neg);
        sample_t s;
        if (loud)
        begin
            s = sample_t'($urandom_range(32767, 16384));
            if (neg)
            begin
                s = sample_t'(-int'($urandom_range(32768, 16384)));
            end
        end
        else
        begin
            case ($urandom_range(7))
                0: s = 16'sh7fff;
                1: s = 16'sh8000;
                2: s = 16'sh0000;
                3: s = 16'shffff;
                4: s = sample_t'(int'($urandom_range(127)) - 64);
                default: s = sample_t'($urandom);
            endcase
        end
        return s;
    endfunction

    function automatic mix_in_t any_item();
        mix_in_t it;
        bit      loud;
        bit      neg;
        loud = ($urandom_range(3) == 0);
        neg = 1'($urandom_range(1));
        for (int p = 0; p < NUM_FIELDS; p++)
        begin
            it.smp[p] = any_sample(loud, neg);
        end
        case ($urandom_range(7))
            0: it.speech = 8'hff;
            1: it.speech = 8'h00;
            default: it.speech = port_mask_t'($urandom);
        endcase
        return it;
    endfunction

    // Offer one item, idling at random first; record what it must produce.
    // Ready is sampled at the falling edge, where it holds its value for the next
    // rising edge.
    task automatic offer(input mix_in_t it, input mix_out_t want);
        while (!calm && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata <= it;
        s_axis_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_axis_tready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        mix_expected.push_back(want);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (mix_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Raise cfg_we with index and data, then update the expected mode; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            REG_BRIDGE_ENABLED: bridge_mode = data[0];
            REG_ACTIVE_MASK:    conn_mask = data;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic [CFG_DATA_W-1:0] bdata, input logic [CFG_DATA_W-1:0] adata);
        settle();
        write_reg(REG_BRIDGE_ENABLED, bdata);
        write_reg(REG_ACTIVE_MASK, adata);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (choke_go && !choke_taken)
        begin
            choke_taken = 1'b1;
            choke_left = CHOKE_LEN;
        end
        if (choke_left > 0)
        begin
            choke_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // Compare each accepted result with the oldest expectation, field by field
    always @(posedge clk)
    begin : result_check
        mix_out_t got;
        mix_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata};
            if (mix_expected.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected: expected nothing, got %h", $time, got);
            end
            else
            begin
                want = mix_expected.pop_front();
                for (int p = 0; p < NUM_FIELDS; p++)
                begin
                    if (got.smp[p] !== want.smp[p])
                    begin
                        mismatches++;
                        $display("%0t: port%0d_out expected %0d got %0d",
                                 $time, p, want.smp[p], got.smp[p]);
                    end
                end
                if (got.present !== want.present)
                begin
                    mismatches++;
                    $display("%0t: present_mask expected %h got %h",
                             $time, want.present, got.present);
                end
                if (got.comfort !== want.comfort)
                begin
                    mismatches++;
                    $display("%0t: comfort_flag expected %b got %b",
                             $time, want.comfort, got.comfort);
                end
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        mix_in_t it;
        // reset values first, then both modes at the mask extremes
        add_row(1'b1, 8'h00, 8'hff, spread(16'sh7fff, 16'sh7fff), 1'b1,
                {1'b0, 8'h00, spread(16'sd0, 16'sd0)});
        add_row(1'b1, 8'h00, 8'h00, spread(-16'sd1, -16'sd1), 1'b1,
                {1'b0, 8'h00, spread(16'sd0, 16'sd0)});
        add_row(1'b1, 8'hff, 8'h00, spread(16'sd1234, 16'sd555), 1'b1,
                {1'b1, 8'hff, spread(16'sd0, 16'sd1234)});
        add_row(1'b1, 8'hff, 8'hff, spread(16'sh7fff, 16'sh7fff), 1'b1,
                {1'b0, 8'hff, spread(16'sh7fff, 16'sh7fff)});
        add_row(1'b1, 8'hff, 8'hff, spread(16'sh8000, 16'sh8000), 1'b1,
                {1'b0, 8'hff, spread(16'sh8000, 16'sh8000)});
        add_row(1'b1, 8'hff, 8'h01, spread(-16'sd700, 16'sd99), 1'b1,
                {1'b1, 8'hff, spread(16'sd0, -16'sd700)});
        add_row(1'b1, 8'h03, 8'h03, spread(-16'sd5000, 16'sd20000), 1'b0, '0);
        // shift rounds towards minus infinity
        add_row(1'b1, 8'hff, 8'h07, {{6{16'sd100}}, 16'hfffd, 16'hffff}, 1'b0, '0);
        // speech on inactive ports is ignored
        add_row(1'b1, 8'h0f, 8'hff,
                {16'h8888, 16'h7777, 16'h6666, 16'h5555, 16'h4444, 16'h3333, 16'h2222, 16'h1111},
                1'b0, '0);
        add_row(1'b1, 8'hff, 8'haa, {4{16'h7fff, 16'h8000}}, 1'b0, '0);
        add_row(1'b1, 8'hff, 8'hfe, {4{16'h8000, 16'h7fff}}, 1'b0, '0);
        add_row(1'b1, 8'h55, 8'hff, {4{16'h4001, 16'hc123}}, 1'b0, '0);
        add_row(1'b0, 8'h00, 8'h00, spread(16'sd5, 16'sd5), 1'b1,
                {1'b1, 8'h01, spread(16'sd0, 16'sd0)});
        add_row(1'b0, 8'h00, 8'hff, spread(16'sd5, 16'sd5), 1'b1,
                {1'b1, 8'h01, spread(16'sd0, 16'sd0)});
        add_row(1'b0, 8'hff, 8'hff, spread(16'sh7fff, 16'sh7fff), 1'b1,
                {1'b0, 8'hff, spread(16'sh7fff, 16'sh7fff)});
        add_row(1'b0, 8'hff, 8'hff, spread(16'sh8000, 16'sh8000), 1'b1,
                {1'b0, 8'hff, spread(16'sh8000, 16'sh8000)});
        add_row(1'b0, 8'hff, 8'h01, spread(16'sd42, 16'sd77), 1'b1,
                {1'b1, 8'hff, spread(16'sd0, 16'sd42)});
        // local speaker is served even when its own port is inactive
        add_row(1'b0, 8'hfe, 8'hfe, spread(-16'sd1, 16'sd300), 1'b0, '0);
        add_row(1'b0, 8'h81, 8'h80, spread(16'sd7, -16'sd9), 1'b0, '0);

        // hold reset, then poke the unused indexes: the mode must not move
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(REG_SPARE_HI, 8'hff);
        write_reg(REG_SPARE_LO, 8'hfe);
        cfg_we <= 1'b0;

        // directed table
        foreach (plan[i])
        begin
            if (plan[i].bridge !== bridge_mode || plan[i].act !== conn_mask)
            begin
                set_mode({7'd0, plan[i].bridge} | 8'h0e, plan[i].act);
            end
            offer(plan[i].item, plan[i].typed ? plan[i].want : mix_minus(plan[i].item));
        end

        // random phases, each under its own mode
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_mode(8'h01, 8'hff);
                1: set_mode(8'hfe, 8'hff);
                2: set_mode(8'h00, 8'h00);
                default: set_mode(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            endcase
            calm = (ph == 3);
            if (ph == 5)
            begin
                choke_go <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                it = any_item();
                offer(it, mix_minus(it));
            end
        end
        calm = 1'b0;

        settle();
        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/cmm_pkg.sv
sv/cmm_lane.sv
sv/cmm_merge.sv
sv/conference_mix_minus_mixer_core.sv
tb/tb_conference_mix_minus_mixer_core.sv
